>>> hw/rtl/tdpt_pkg.sv
// Shared types for the trial-division prime test.
package tdpt_pkg;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_status_t;

endpackage

>>> hw/rtl/tdpt_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module tdpt_rem #(
  parameter int UB = 31,
  parameter int DW = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [UB-1:0]         value,
  input  logic [DW-1:0]         divisor,
  output tdpt_pkg::rem_status_t status
);

  localparam int CW = $clog2(UB + 1);

  logic [UB-1:0] val_sr;
  logic [DW-1:0] rem;
  logic [DW-1:0] rem_next;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  always_comb begin
    trial    = {rem, val_sr[UB-1]};
    diff     = trial - {1'b0, divisor};
    rem_next = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(UB);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_sr <= value;
      rem    <= '0;
    end else if (busy) begin
      val_sr <= {val_sr[UB-2:0], 1'b0};
      rem    <= rem_next;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign status.zero = (rem == '0);

endmodule

>>> hw/rtl/trial_division_prime_test_top.sv
// Top level: trial-division prime test sequencer with result register.
// Negative, zero, one, two and even candidates are decided without trial division.
// Otherwise each odd trial divisor takes one bound check, VALUE_BITS - 1 serial
// remainder steps and one completion step; worst case about 23170 trials at 32
// bits. One candidate in flight at a time.
// Reset (synchronous, active high) returns to idle and drops any pending result.
module trial_division_prime_test_top #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  candidate_valid,
  output logic                  candidate_ready,
  input  logic signed [31:0]    candidate,
  output logic                  is_prime_valid,
  input  logic                  is_prime_ready,
  output logic                  is_prime
);

  localparam int UB = VALUE_BITS - 1;
  localparam int DW = (UB + 1) / 2 + 1;
  localparam int SW = 2 * DW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state;
  logic [UB-1:0] value;
  logic [DW-1:0] d;
  logic [SW-1:0] sq;
  logic          result;
  logic          res_valid;
  logic          res_bit;
  logic          res_load;
  logic          sign;
  logic [UB-1:0] mag;
  logic          in_xfer;
  logic          rem_start;
  logic          bound_ok;
  tdpt_pkg::rem_status_t rem_st;

  assign sign            = candidate[VALUE_BITS-1];
  assign mag             = candidate[UB-1:0];
  assign candidate_ready = (state == S_IDLE);
  assign in_xfer         = candidate_valid && candidate_ready;
  assign bound_ok        = (sq <= SW'(value));
  assign rem_start       = (state == S_CHECK) && bound_ok;
  assign res_load        = (state == S_DONE) && (!res_valid || is_prime_ready);

  tdpt_rem #(
    .UB(UB),
    .DW(DW)
  ) u_rem (
    .clk    (clk),
    .rst    (rst),
    .start  (rem_start),
    .value  (value),
    .divisor(d),
    .status (rem_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (is_prime_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            value <= mag;
            d     <= DW'(3);
            sq    <= SW'(9);
            priority if (sign || (mag <= UB'(1))) begin
              result <= 1'b0;
              state  <= S_DONE;
            end else if (mag == UB'(2)) begin
              result <= 1'b1;
              state  <= S_DONE;
            end else if (!mag[0]) begin
              result <= 1'b0;
              state  <= S_DONE;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (bound_ok) begin
            state <= S_DIV;
          end else begin
            result <= 1'b1;
            state  <= S_DONE;
          end
        end
        S_DIV: begin
          if (rem_st.done) begin
            if (rem_st.zero) begin
              result <= 1'b0;
              state  <= S_DONE;
            end else begin
              d     <= d + DW'(2);
              sq    <= sq + SW'({d, 2'b00}) + SW'(4);
              state <= S_CHECK;
            end
          end
        end
        S_DONE: begin
          if (res_load) begin
            res_bit <= result;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign is_prime_valid = res_valid;
  assign is_prime       = res_bit;

`ifndef ASSERT_OFF
  a_busy_in_div: assert property (@(posedge clk) disable iff (rst)
    rem_st.busy |-> (state == S_DIV))
    else $error("remainder unit busy outside divide state");

  a_odd_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> d[0])
    else $error("trial divisor is even");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state != S_IDLE))
    else $error("accepted candidate left idle");

  a_exact_div_not_prime: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIV) && rem_st.done && rem_st.zero) |=> ((state == S_DONE) && !result))
    else $error("exact division not reported as composite");

  a_start_bounded: assert property (@(posedge clk) disable iff (rst)
    rem_start |=> (rem_st.busy && (state == S_DIV)))
    else $error("remainder start not followed by busy divide");
`endif

endmodule
